// ===== hdl/rst2d_pkg.sv =====
// Shared types and constants for the two-dimensional sum tree block.
`timescale 1ns / 1ps
package rst2d_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int REQ_W      = 2;
    localparam int COORD_W    = 6;
    localparam int CNT_W      = 7;
    localparam int IN_VAL_W   = 32;
    localparam int OUT_SUM_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR,
        DP_SC_RD,
        DP_SC_WR,
        DP_SR_INIT,
        DP_SR_RD,
        DP_SR_WR,
        DP_SR_NEXT,
        DP_Q_LO,
        DP_Q_HI,
        DP_Q_SHIFT,
        DP_Q_RD,
        DP_Q_ACC
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   cfg_we;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             bad;
        logic             empty;
        logic             cfg_hit;
        logic             clr_last;
        logic             sc_more;
        logic             sr_row_more;
        logic             sr_col_more;
        logic             q_row_more;
        logic             i0_odd;
        logic             i1_odd;
        logic             q_col_more;
    } t_dp_status;

endpackage

// ===== hdl/rect_sum_tree_2d_top.sv =====
// Top level of the two-dimensional rectangle sum tree.
`timescale 1ns / 1ps
// Usage: raise start with a request while busy is low; the transfer
// happens on that edge. Requests: set point, rectangle sum query, clear all.
// Exactly one result follows each request: o_done is high for one cycle
// with o_rect_sum and o_status valid. The receiver cannot stall; results
// must be taken in that cycle. busy stays high until after that cycle.
// Row and column counts are written on the config channel (i_cfg_valid,
// o_cfg_ready, i_cfg_index, i_cfg_data) while idle; o_cfg_ready is low
// while start is high. A write to either register starts a store clear.
// The datapath takes at most one memory step per cycle (two reads or one
// write on the tree memory). Out-of-range, empty and unused-code requests
// give o_done in the cycle right after the transfer. A clear, a count write
// and reset each sweep all 2^(clog2(2*MAX_ROWS)+clog2(2*MAX_COLS)) memory
// entries (16384 at defaults), with busy high throughout.
module rect_sum_tree_2d_top
    import rst2d_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [REQ_W-1:0]            i_req_type,
    input  logic [COORD_W-1:0]          i_row_a,
    input  logic [COORD_W-1:0]          i_col_a,
    input  logic [COORD_W-1:0]          i_row_b,
    input  logic [COORD_W-1:0]          i_col_b,
    input  logic signed [IN_VAL_W-1:0]  i_new_value,
    output logic                        o_done,
    output logic signed [OUT_SUM_W-1:0] o_rect_sum,
    output logic                        o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status st;

    rst2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cfg_valid (i_cfg_valid),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_cfg_ready (o_cfg_ready)
    );

    rst2d_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_row_a     (i_row_a),
        .i_col_a     (i_col_a),
        .i_row_b     (i_row_b),
        .i_col_b     (i_col_b),
        .i_new_value (i_new_value),
        .o_rect_sum  (o_rect_sum),
        .o_status    (o_status)
    );

endmodule

// ===== hdl/rst2d_datapath.sv =====
// Datapath: tree memory, walk index registers, adder and result registers.
`timescale 1ns / 1ps
module rst2d_datapath
    import rst2d_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_st,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [REQ_W-1:0]            i_req_type,
    input  logic [COORD_W-1:0]          i_row_a,
    input  logic [COORD_W-1:0]          i_col_a,
    input  logic [COORD_W-1:0]          i_row_b,
    input  logic [COORD_W-1:0]          i_col_b,
    input  logic signed [IN_VAL_W-1:0]  i_new_value,
    output logic signed [OUT_SUM_W-1:0] o_rect_sum,
    output logic                        o_status
);

    localparam int RW    = $clog2(2 * MAX_ROWS);
    localparam int CW    = $clog2(2 * MAX_COLS);
    localparam int IR    = $clog2(2 * MAX_ROWS + 1);
    localparam int IC    = $clog2(2 * MAX_COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CNT_W-1:0] ROWS_RST = CNT_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
    localparam logic [CNT_W-1:0] COLS_RST = CNT_W'((MAX_COLS < 64) ? MAX_COLS : 64);

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic [CNT_W-1:0]      r_row_cnt, r_col_cnt;
    logic [AW-1:0]         r_clr;
    logic [IR-1:0]         r_li, r_i, r_i0, r_i1;
    logic [IC-1:0]         r_lj, r_j, r_j1, r_c1;
    logic                  r_en_a, r_en_b;
    logic [VALUE_BITS-1:0] r_rd_a, r_rd_b, r_acc;
    logic                  r_status;

    logic [7:0]            ra8, ca8, rb8, cb8;
    logic [IR-1:0]         li_in, i1_in;
    logic [IC-1:0]         lj_in, j1_in;
    logic                  bad_set, bad_qry;
    logic [AW-1:0]         addr_a, addr_b, addr_w;
    logic [VALUE_BITS-1:0] wdata, pair_sum;
    logic                  we;
    logic [CNT_W-1:0]      cfg_clamped;
    logic [CNT_W-1:0]      cfg_lim;

    function automatic logic [AW-1:0] mk_addr(input logic [IR-1:0] ri, input logic [IC-1:0] cj);
        return {ri[RW-1:0], cj[CW-1:0]};
    endfunction

    // Map request coordinates onto tree leaf indexes
    assign ra8   = {2'b00, i_row_a} + {1'b0, r_row_cnt};
    assign ca8   = {2'b00, i_col_a} + {1'b0, r_col_cnt};
    assign rb8   = {2'b00, i_row_b} + {1'b0, r_row_cnt} + 8'd1;
    assign cb8   = {2'b00, i_col_b} + {1'b0, r_col_cnt} + 8'd1;
    assign li_in = IR'(ra8);
    assign lj_in = IC'(ca8);
    assign i1_in = IR'(rb8);
    assign j1_in = IC'(cb8);

    // Check coordinates against the grid size
    assign bad_set = ({1'b0, i_row_a} >= r_row_cnt) || ({1'b0, i_col_a} >= r_col_cnt);
    assign bad_qry = bad_set || ({1'b0, i_row_b} >= r_row_cnt)
                             || ({1'b0, i_col_b} >= r_col_cnt);

    always_comb begin
        o_st.req   = i_req_type;
        o_st.empty = (i_row_a > i_row_b) || (i_col_a > i_col_b);
        case (i_req_type)
            REQ_SET:   o_st.bad = bad_set;
            REQ_QUERY: o_st.bad = bad_qry;
            REQ_CLEAR: o_st.bad = 1'b0;
            default:   o_st.bad = 1'b1;
        endcase
        o_st.cfg_hit     = (i_cfg_index == CFG_ROW_COUNT) || (i_cfg_index == CFG_COL_COUNT);
        o_st.clr_last    = &r_clr;
        o_st.sc_more     = r_j > IC'(1);
        o_st.sr_row_more = r_i > IR'(1);
        o_st.sr_col_more = r_j != '0;
        o_st.q_row_more  = r_i0 < r_i1;
        o_st.i0_odd      = r_i0[0];
        o_st.i1_odd      = r_i1[0];
        o_st.q_col_more  = r_j < r_j1;
    end

    // Select memory read and write addresses
    assign pair_sum = r_rd_a + r_rd_b;

    always_comb begin
        addr_a = mk_addr(r_i, r_j);
        addr_b = mk_addr(r_i ^ IR'(1), r_j);
        addr_w = mk_addr(r_li, r_lj);
        wdata  = pair_sum;
        we     = 1'b0;
        case (i_cmd.op)
            DP_LOAD: begin
                addr_w = mk_addr(li_in, lj_in);
                wdata  = VALUE_BITS'(i_new_value);
                we     = (i_req_type == REQ_SET) && !bad_set;
            end
            DP_CLR: begin
                addr_w = r_clr;
                wdata  = '0;
                we     = 1'b1;
            end
            DP_SC_RD: begin
                addr_a = mk_addr(r_li, r_j);
                addr_b = mk_addr(r_li, r_j ^ IC'(1));
            end
            DP_SC_WR: begin
                addr_w = mk_addr(r_li, r_j >> 1);
                we     = 1'b1;
            end
            DP_SR_WR: begin
                addr_w = mk_addr(r_i >> 1, r_j);
                we     = 1'b1;
            end
            DP_Q_RD: begin
                addr_b = mk_addr(r_i, r_j1 - IC'(1));
            end
            default: begin
            end
        endcase
    end

    // Write at most one entry and read two entries per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr_w] <= wdata;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    // Clamp a written count into the supported range
    assign cfg_lim     = (MAX_ROWS > 127) ? CNT_W'(127) : CNT_W'(MAX_ROWS);
    always_comb begin
        logic [CNT_W-1:0] lim;
        lim = (i_cfg_index == CFG_ROW_COUNT) ? cfg_lim
            : ((MAX_COLS > 127) ? CNT_W'(127) : CNT_W'(MAX_COLS));
        if (i_cfg_data == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (i_cfg_data > lim) begin
            cfg_clamped = lim;
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    // Hold grid size and clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= ROWS_RST;
            r_col_cnt <= COLS_RST;
            r_clr     <= '0;
        end else begin
            if (i_cmd.cfg_we && i_cfg_index == CFG_ROW_COUNT) begin
                r_row_cnt <= cfg_clamped;
            end
            if (i_cmd.cfg_we && i_cfg_index == CFG_COL_COUNT) begin
                r_col_cnt <= cfg_clamped;
            end
            if (i_cmd.op == DP_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // Advance walk indexes and the accumulator
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_li     <= li_in;
                r_lj     <= lj_in;
                r_i      <= li_in;
                r_j      <= lj_in;
                r_i0     <= li_in;
                r_i1     <= i1_in;
                r_c1     <= j1_in;
                r_acc    <= '0;
                r_status <= o_st.bad;
            end
            DP_SC_WR: r_j <= r_j >> 1;
            DP_SR_INIT: begin
                r_i <= r_li;
                r_j <= r_lj;
            end
            DP_SR_WR: r_j <= r_j >> 1;
            DP_SR_NEXT: begin
                r_i <= r_i >> 1;
                r_j <= r_lj;
            end
            DP_Q_LO: begin
                r_i  <= r_i0;
                r_i0 <= r_i0 + IR'(1);
                r_j  <= r_lj;
                r_j1 <= r_c1;
            end
            DP_Q_HI: begin
                r_i  <= r_i1 - IR'(1);
                r_i1 <= r_i1 - IR'(1);
                r_j  <= r_lj;
                r_j1 <= r_c1;
            end
            DP_Q_SHIFT: begin
                r_i0 <= r_i0 >> 1;
                r_i1 <= r_i1 >> 1;
            end
            DP_Q_RD: begin
                r_en_a <= r_j[0];
                r_en_b <= r_j1[0];
                r_j    <= (r_j + IC'(r_j[0])) >> 1;
                r_j1   <= r_j1 >> 1;
            end
            DP_Q_ACC: begin
                r_acc <= r_acc + (r_en_a ? r_rd_a : '0) + (r_en_b ? r_rd_b : '0);
            end
            default: begin
            end
        endcase
    end

    assign o_rect_sum = OUT_SUM_W'(r_acc);
    assign o_status   = r_status;

endmodule

// ===== hdl/rst2d_ctrl.sv =====
// Controller: request sequencer driving the datapath one step a cycle.
`timescale 1ns / 1ps
module rst2d_ctrl
    import rst2d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_cfg_valid,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done,
    output logic       o_cfg_ready
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLEAR = 11'b00000000010,
        S_SC    = 11'b00000000100,
        S_SCW   = 11'b00000001000,
        S_SR    = 11'b00000010000,
        S_SRW   = 11'b00000100000,
        S_QLO   = 11'b00001000000,
        S_QHI   = 11'b00010000000,
        S_QCOL  = 11'b00100000000,
        S_QACC  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_reply, n_reply;

    // Decode the next step
    always_comb begin
        n_state      = r_state;
        n_reply      = r_reply;
        o_cmd.op     = DP_NOP;
        o_cmd.cfg_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                // A request transfer takes the cycle; config waits behind it
                o_cmd.cfg_we = i_cfg_valid && !i_start;
                if (i_start) begin
                    o_cmd.op = DP_LOAD;
                    if (i_st.bad) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_st.req)
                            REQ_SET:   n_state = S_SC;
                            REQ_QUERY: n_state = i_st.empty ? S_DONE : S_QLO;
                            REQ_CLEAR: begin
                                n_state = S_CLEAR;
                                n_reply = 1'b1;
                            end
                            default:   n_state = S_DONE;
                        endcase
                    end
                end else if (i_cfg_valid && i_st.cfg_hit) begin
                    n_state = S_CLEAR;
                    n_reply = 1'b0;
                end
            end
            S_CLEAR: begin
                o_cmd.op = DP_CLR;
                if (i_st.clr_last) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_SC: begin
                if (i_st.sc_more) begin
                    o_cmd.op = DP_SC_RD;
                    n_state  = S_SCW;
                end else begin
                    o_cmd.op = DP_SR_INIT;
                    n_state  = S_SR;
                end
            end
            S_SCW: begin
                o_cmd.op = DP_SC_WR;
                n_state  = S_SC;
            end
            S_SR: begin
                if (!i_st.sr_row_more) begin
                    n_state = S_DONE;
                end else if (i_st.sr_col_more) begin
                    o_cmd.op = DP_SR_RD;
                    n_state  = S_SRW;
                end else begin
                    o_cmd.op = DP_SR_NEXT;
                end
            end
            S_SRW: begin
                o_cmd.op = DP_SR_WR;
                n_state  = S_SR;
            end
            S_QLO: begin
                if (!i_st.q_row_more) begin
                    n_state = S_DONE;
                end else if (i_st.i0_odd) begin
                    o_cmd.op = DP_Q_LO;
                    n_state  = S_QCOL;
                end else begin
                    n_state = S_QHI;
                end
            end
            S_QHI: begin
                if (i_st.i1_odd) begin
                    o_cmd.op = DP_Q_HI;
                    n_state  = S_QCOL;
                end else begin
                    o_cmd.op = DP_Q_SHIFT;
                    n_state  = S_QLO;
                end
            end
            S_QCOL: begin
                if (i_st.q_col_more) begin
                    o_cmd.op = DP_Q_RD;
                    n_state  = S_QACC;
                end else begin
                    n_state = S_QHI;
                end
            end
            S_QACC: begin
                o_cmd.op = DP_Q_ACC;
                n_state  = S_QCOL;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; sweep the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;

endmodule
